[rtl/fcce_pkg.sv]
// Shared types and constants for the cluster chain engine.
package fcce_pkg;

    localparam int TABLE_DEPTH  = 4096;
    localparam int ROOT_CLUSTER = 1;
    localparam int ENTRY_WIDTH  = 28;
    localparam int ADDR_W       = $clog2(TABLE_DEPTH);
    localparam int LEN_W        = 13;

    localparam logic [ENTRY_WIDTH-1:0] END_OF_CHAIN = {ENTRY_WIDTH{1'b1}};
    localparam logic [LEN_W-1:0]       DEPTH_LEN    = LEN_W'(TABLE_DEPTH);
    localparam logic [LEN_W-1:0]       FIRST_DATA   = LEN_W'(ROOT_CLUSTER + 1);
    localparam logic [LEN_W-1:0]       RESET_LEN    = LEN_W'(4096);

    // Command codes.
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // One cycle of requests from the controller to the table memory.
    typedef struct packed {
        logic                   we;
        logic [ADDR_W-1:0]      waddr;
        logic [ENTRY_WIDTH-1:0] wdata;
        logic                   re;
        logic [ADDR_W-1:0]      raddr;
    } mem_req_t;

endpackage

[rtl/fcce_ram.sv]
// Simple dual-port table memory with registered read data.
module fcce_ram #(
    parameter int DEPTH  = 4096,
    parameter int WIDTH  = 28,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/fcce_ctrl.sv]
// Command sequencer: table clearing, next-fit search, chain walk and result register.
module fcce_ctrl import fcce_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [LEN_W-1:0]       cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             in_cmd,
    input  logic [ADDR_W-1:0]      in_cluster,
    input  logic [ADDR_W-1:0]      in_prev,
    input  logic [ENTRY_WIDTH-1:0] in_value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [ADDR_W-1:0]      out_new,
    output logic [ENTRY_WIDTH-1:0] out_rd,
    output logic [1:0]             out_status,
    output mem_req_t               mem_req,
    input  logic [ENTRY_WIDTH-1:0] mem_rdata
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_SEARCH, S_ALLOC_EOC, S_ALLOC_LINK,
        S_WALK_CHK, S_WALK_RD, S_READ_WAIT, S_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    logic [1:0]             cmd_reg, cmd_next;
    logic [ADDR_W-1:0]      cl_reg, cl_next;
    logic [ADDR_W-1:0]      prev_reg, prev_next;
    logic [ENTRY_WIDTH-1:0] val_reg, val_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [ADDR_W-1:0]      last_reg, last_next;
    logic [LEN_W-1:0]       scan_reg, scan_next;
    logic                   phase2_reg, phase2_next;
    logic                   pend_reg, pend_next;
    logic [ADDR_W-1:0]      pend_addr_reg, pend_addr_next;
    logic [ADDR_W-1:0]      found_reg, found_next;
    logic [ENTRY_WIDTH-1:0] cur_reg, cur_next;
    logic [ADDR_W-1:0]      clr_reg, clr_next;
    logic [ADDR_W-1:0]      res_new_reg, res_new_next;
    logic [ENTRY_WIDTH-1:0] res_rd_reg, res_rd_next;
    logic [1:0]             res_st_reg, res_st_next;
    logic                   m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0]      m_new_reg, m_new_next;
    logic [ENTRY_WIDTH-1:0] m_rd_reg, m_rd_next;
    logic [1:0]             m_st_reg, m_st_next;

    logic [LEN_W-1:0] eff_len;
    logic [LEN_W-1:0] start;
    logic [LEN_W-1:0] lim2;
    logic             cl_bad;
    logic             prev_bad;
    mem_req_t         req;

    // Length in effect, the bounds of the two search passes and the range checks.
    assign eff_len  = (len_reg > DEPTH_LEN) ? DEPTH_LEN : len_reg;
    assign start    = {1'b0, last_reg} + LEN_W'(1);
    assign lim2     = (start < eff_len) ? start : eff_len;
    assign cl_bad   = ({1'b0, cl_reg} >= eff_len);
    assign prev_bad = ({1'b0, prev_reg} >= eff_len);

    // Next-state and memory request logic.
    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        cl_next        = cl_reg;
        prev_next      = prev_reg;
        val_next       = val_reg;
        len_next       = cfg_we ? cfg_wdata : len_reg;
        last_next      = last_reg;
        scan_next      = scan_reg;
        phase2_next    = phase2_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        found_next     = found_reg;
        cur_next       = cur_reg;
        clr_next       = clr_reg;
        res_new_next   = res_new_reg;
        res_rd_next    = res_rd_reg;
        res_st_next    = res_st_reg;
        m_valid_next   = m_valid_reg && !out_ready;
        m_new_next     = m_new_reg;
        m_rd_next      = m_rd_reg;
        m_st_next      = m_st_reg;
        req            = '0;

        case (state_reg)
            S_CLEAR: begin
                req.we    = 1'b1;
                req.waddr = clr_reg;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(TABLE_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_valid) begin
                    cmd_next   = in_cmd;
                    cl_next    = in_cluster;
                    prev_next  = in_prev;
                    val_next   = in_value;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                res_new_next = '0;
                res_rd_next  = '0;
                res_st_next  = ST_OK;
                state_next   = S_FINISH;
                case (cmd_reg)
                    CMD_ALLOC: begin
                        if (cl_reg != '0 && cl_bad) begin
                            res_st_next = ST_RANGE;
                        end else begin
                            scan_next   = start;
                            phase2_next = 1'b0;
                            pend_next   = 1'b0;
                            state_next  = S_SEARCH;
                        end
                    end
                    CMD_FREE: begin
                        if (cl_reg != '0) begin
                            if (prev_reg != '0 && prev_bad) begin
                                res_st_next = ST_RANGE;
                            end else begin
                                req.we     = (prev_reg != '0);
                                req.waddr  = prev_reg;
                                req.wdata  = END_OF_CHAIN;
                                cur_next   = ENTRY_WIDTH'(cl_reg);
                                state_next = S_WALK_CHK;
                            end
                        end
                    end
                    CMD_WRITE: begin
                        if (cl_reg == '0 || cl_bad) begin
                            res_st_next = ST_RANGE;
                        end else begin
                            req.we    = 1'b1;
                            req.waddr = cl_reg;
                            req.wdata = val_reg;
                        end
                    end
                    default: begin
                        if (cl_reg == '0 || cl_bad) begin
                            res_st_next = ST_RANGE;
                        end else begin
                            req.re     = 1'b1;
                            req.raddr  = cl_reg;
                            state_next = S_READ_WAIT;
                        end
                    end
                endcase
            end
            S_SEARCH: begin
                // One read issued per cycle; the previous read is checked here.
                if (pend_reg && mem_rdata == '0) begin
                    found_next = pend_addr_reg;
                    state_next = S_ALLOC_EOC;
                end else if (!phase2_reg) begin
                    if (scan_reg < eff_len) begin
                        req.re         = 1'b1;
                        req.raddr      = scan_reg[ADDR_W-1:0];
                        pend_next      = 1'b1;
                        pend_addr_next = scan_reg[ADDR_W-1:0];
                        scan_next      = scan_reg + LEN_W'(1);
                    end else begin
                        phase2_next = 1'b1;
                        scan_next   = FIRST_DATA;
                        pend_next   = 1'b0;
                    end
                end else if (scan_reg < lim2) begin
                    req.re         = 1'b1;
                    req.raddr      = scan_reg[ADDR_W-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = scan_reg[ADDR_W-1:0];
                    scan_next      = scan_reg + LEN_W'(1);
                end else if (pend_reg) begin
                    pend_next = 1'b0;
                end else begin
                    res_st_next = ST_FULL;
                    state_next  = S_FINISH;
                end
            end
            S_ALLOC_EOC: begin
                req.we       = 1'b1;
                req.waddr    = found_reg;
                req.wdata    = END_OF_CHAIN;
                last_next    = found_reg;
                res_new_next = found_reg;
                state_next   = (cl_reg != '0) ? S_ALLOC_LINK : S_FINISH;
            end
            S_ALLOC_LINK: begin
                // A link to itself lands after the end mark and overwrites it.
                req.we     = 1'b1;
                req.waddr  = cl_reg;
                req.wdata  = ENTRY_WIDTH'(found_reg);
                state_next = S_FINISH;
            end
            S_WALK_CHK: begin
                if (cur_reg == '0 || cur_reg == END_OF_CHAIN) begin
                    state_next = S_FINISH;
                end else if (cur_reg >= ENTRY_WIDTH'(eff_len)) begin
                    res_st_next = ST_RANGE;
                    state_next  = S_FINISH;
                end else begin
                    req.re     = 1'b1;
                    req.raddr  = cur_reg[ADDR_W-1:0];
                    state_next = S_WALK_RD;
                end
            end
            S_WALK_RD: begin
                // Free the entry and follow its old link.
                req.we     = 1'b1;
                req.waddr  = cur_reg[ADDR_W-1:0];
                req.wdata  = '0;
                cur_next   = mem_rdata;
                state_next = S_WALK_CHK;
            end
            S_READ_WAIT: begin
                res_rd_next = mem_rdata;
                state_next  = S_FINISH;
            end
            S_FINISH: begin
                if (!m_valid_reg || out_ready) begin
                    m_valid_next = 1'b1;
                    m_new_next   = res_new_reg;
                    m_rd_next    = res_rd_reg;
                    m_st_next    = res_st_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            len_reg     <= RESET_LEN;
            last_reg    <= ADDR_W'(ROOT_CLUSTER);
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
            phase2_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            last_reg    <= last_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
            phase2_reg  <= phase2_next;
        end
        cmd_reg       <= cmd_next;
        cl_reg        <= cl_next;
        prev_reg      <= prev_next;
        val_reg       <= val_next;
        scan_reg      <= scan_next;
        pend_addr_reg <= pend_addr_next;
        found_reg     <= found_next;
        cur_reg       <= cur_next;
        res_new_reg   <= res_new_next;
        res_rd_reg    <= res_rd_next;
        res_st_reg    <= res_st_next;
        m_new_reg     <= m_new_next;
        m_rd_reg      <= m_rd_next;
        m_st_reg      <= m_st_next;
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = m_valid_reg;
    assign out_new    = m_new_reg;
    assign out_rd     = m_rd_reg;
    assign out_status = m_st_reg;
    assign mem_req    = req;

    // The memory never sees a read and a write in the same cycle.
    assert property (@(posedge aclk) disable iff (!aresetn) !(req.we && req.re))
        else $error("table read and write in the same cycle");

    // An accepted item always goes to dispatch next.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> (state_reg == S_DISPATCH))
        else $error("accepted item not dispatched");

    // A found cluster never lies at or below the root.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ALLOC_EOC) |-> (found_reg >= ADDR_W'(ROOT_CLUSTER + 1)))
        else $error("allocation found a reserved cluster");

endmodule

[rtl/fat_cluster_chain_engine_top.sv]
// Top level of the cluster chain engine: stream ports, table memory and sequencer.
//
// The block holds a 4096-entry allocation table in one on-chip memory and serves one
// command per item. After reset it clears the table with s_tready low; configuration
// writes are taken during that time. An allocate scans the table at one entry per
// cycle. In a free, each link costs a read and a write on the memory ports. The next
// item is taken while a finished result waits on the m_ side.
module fat_cluster_chain_engine_top import fcce_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [12:0] cfg_wdata,      // table_length
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,        // cluster[11:0], prev_cluster[23:12],
                                        // entry_value[51:24], zero fill
    input  logic [1:0]  s_tuser,        // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata         // new_cluster[11:0], read_value[39:12],
                                        // status[41:40], zero fill
);

    mem_req_t               mem_req;
    logic [ENTRY_WIDTH-1:0] mem_rdata;
    logic [ADDR_W-1:0]      out_new;
    logic [ENTRY_WIDTH-1:0] out_rd;
    logic [1:0]             out_status;

    fcce_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENTRY_WIDTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    fcce_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (s_tuser),
        .in_cluster (s_tdata[11:0]),
        .in_prev    (s_tdata[23:12]),
        .in_value   (s_tdata[51:24]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_new    (out_new),
        .out_rd     (out_rd),
        .out_status (out_status),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata)
    );

    // Pack the result fields, lowest field first.
    assign m_tdata = {6'b0, out_status, out_rd, out_new};

endmodule

[test/tb_fat_cluster_chain_engine_checker.sv]
// Checker for the cluster chain engine: table predictor and result comparison.
`timescale 1ns / 100ps

module tb_fat_cluster_chain_engine_checker import fcce_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [12:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    output int          fail_count,
    output int          pending_count
);

    typedef struct packed {
        logic [11:0]            new_cluster;
        logic [ENTRY_WIDTH-1:0] read_value;
        logic [1:0]             status;
    } fat_result_t;

    logic [ENTRY_WIDTH-1:0] fat_links [TABLE_DEPTH];
    logic [11:0]            last_alloc;
    logic [LEN_W-1:0]       length_reg;
    fat_result_t            expected_results [$];

    assign pending_count = expected_results.size();

    function automatic int active_length();
        return (int'(length_reg) < TABLE_DEPTH) ? int'(length_reg) : TABLE_DEPTH;
    endfunction

    // Next-fit search over the free entries.
    function automatic int search_free(int from_idx, int to_idx);
        for (int i = from_idx; i < to_idx; i++)
            if (fat_links[i] == '0) return i;
        return 0;
    endfunction

    // Predict one command and update the shadow table.
    function automatic fat_result_t serve_command(logic [1:0] op, int cl, int prev_cl,
                                                  logic [ENTRY_WIDTH-1:0] value);
        fat_result_t r;
        int len, start, found, cur;
        r = '0;
        len = active_length();
        case (op)
            CMD_ALLOC: begin
                if (cl != 0 && cl >= len) begin
                    r.status = ST_RANGE;
                end else begin
                    start = int'(last_alloc) + 1;
                    if (start < ROOT_CLUSTER + 1) start = ROOT_CLUSTER + 1;
                    found = search_free(start, len);
                    if (found == 0)
                        found = search_free(ROOT_CLUSTER + 1, (start < len) ? start : len);
                    if (found == 0) begin
                        r.status = ST_FULL;
                    end else begin
                        fat_links[found] = END_OF_CHAIN;
                        if (cl != 0) fat_links[cl] = ENTRY_WIDTH'(found);
                        last_alloc = 12'(found);
                        r.new_cluster = 12'(found);
                    end
                end
            end
            CMD_FREE: begin
                if (cl != 0) begin
                    if (prev_cl != 0 && prev_cl >= len) begin
                        r.status = ST_RANGE;
                    end else begin
                        if (prev_cl != 0) fat_links[prev_cl] = END_OF_CHAIN;
                        cur = cl;
                        for (int g = 0; g <= TABLE_DEPTH; g++) begin
                            if (cur == 0 || cur == int'(END_OF_CHAIN)) break;
                            if (cur >= len) begin
                                r.status = ST_RANGE;
                                break;
                            end
                            found = int'(fat_links[cur]);
                            fat_links[cur] = '0;
                            cur = found;
                        end
                    end
                end
            end
            CMD_WRITE: begin
                if (cl == 0 || cl >= len) r.status = ST_RANGE;
                else fat_links[cl] = value;
            end
            default: begin
                if (cl == 0 || cl >= len) r.status = ST_RANGE;
                else r.read_value = fat_links[cl];
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // Track configuration, accepted commands and returned results.
    always @(posedge aclk) begin
        fat_result_t want;
        fat_result_t got;
        if (!aresetn) begin
            foreach (fat_links[i]) fat_links[i] = '0;
            last_alloc = 12'(ROOT_CLUSTER);
            length_reg = RESET_LEN;
        end else begin
            if (cfg_we) length_reg = cfg_wdata;
            if (s_tvalid && s_tready)
                expected_results.push_back(serve_command(s_tuser, int'(s_tdata[11:0]),
                    int'(s_tdata[23:12]), s_tdata[51:24]));
            if (m_tvalid && m_tready) begin
                got.new_cluster = m_tdata[11:0];
                got.read_value  = m_tdata[39:12];
                got.status      = m_tdata[41:40];
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", int'(m_tdata), 0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.new_cluster !== want.new_cluster)
                        report_mismatch("new_cluster", int'(got.new_cluster),
                                        int'(want.new_cluster));
                    if (got.read_value !== want.read_value)
                        report_mismatch("read_value", int'(got.read_value),
                                        int'(want.read_value));
                    if (got.status !== want.status)
                        report_mismatch("status", int'(got.status), int'(want.status));
                end
            end
        end
    end

    initial fail_count = 0;

endmodule

[test/tb_fat_cluster_chain_engine_top.sv]
// Testbench top for the cluster chain engine: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_fat_cluster_chain_engine_top;
    import fcce_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [12:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    int          fail_count;
    int          pending_count;
    bit          idle_enabled;
    int          cur_length;
    logic [11:0] recent_alloc;
    int          stall_left = 0;

    fat_cluster_chain_engine_top u_top (.*);

    tb_fat_cluster_chain_engine_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver stalls in random bursts while idling is enabled.
    always @(posedge aclk) begin
        if (idle_enabled && stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 16);
            m_tready   <= 1'b0;
        end else begin
            stall_left <= 0;
            m_tready   <= 1'b1;
        end
    end

    // Sometimes hold off the sender for a random burst while idling is enabled.
    task automatic sender_gap();
        if (idle_enabled && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 17)) @(posedge aclk);
    endtask

    // Offer one item, wait for its acceptance and drop valid.
    task automatic send_command(logic [1:0] op, int cl, int prev_cl, logic [27:0] value);
        sender_gap();
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'd0, value, 12'(prev_cl), 12'(cl)};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain_results();
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_length(int len);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= 13'(len);
        @(posedge aclk);
        cfg_we <= 1'b0;
        cur_length = (len < TABLE_DEPTH) ? len : TABLE_DEPTH;
    endtask

    // Mostly valid chain operations, with some out of range and random noise.
    task automatic random_command();
        int pick, top_idx;
        top_idx = (cur_length > 2) ? cur_length - 1 : 1;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            send_command(CMD_ALLOC, ($urandom_range(0, 1) == 0) ? 0 : int'(recent_alloc),
                         0, 0);
        else if (pick < 5)
            send_command(CMD_FREE, $urandom_range(1, top_idx),
                         ($urandom_range(0, 2) == 0) ? $urandom_range(0, top_idx) : 0,
                         28'($urandom));
        else if (pick < 6)
            send_command(CMD_WRITE, $urandom_range(1, top_idx), 0,
                         ($urandom_range(0, 1) == 0) ? 28'($urandom_range(0, top_idx))
                                                     : 28'($urandom));
        else if (pick < 8)
            send_command(CMD_READ, $urandom_range(1, top_idx), 0, 0);
        else
            send_command(2'($urandom), $urandom_range(0, 4095), $urandom_range(0, 4095),
                         28'($urandom));
    endtask

    // Remember the newest allocation so later allocates extend real chains.
    always @(posedge aclk)
        if (m_tvalid && m_tready && m_tdata[11:0] != 0) recent_alloc <= m_tdata[11:0];

    initial begin
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = CMD_ALLOC;
        m_tready     = 1'b0;
        idle_enabled = 1'b1;
        cur_length   = TABLE_DEPTH;
        recent_alloc = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed small table cases, then a length above the table depth.
        set_length(2);
        send_command(CMD_ALLOC, 0, 0, 0);
        send_command(CMD_READ, 1, 0, 0);
        send_command(CMD_WRITE, 0, 0, 28'hFFFFFFF);
        set_length(6);
        send_command(CMD_ALLOC, 7, 0, 0);
        send_command(CMD_ALLOC, 0, 0, 0);
        send_command(CMD_ALLOC, 2, 0, 0);
        send_command(CMD_ALLOC, 3, 0, 0);
        send_command(CMD_ALLOC, 4, 0, 0);
        send_command(CMD_ALLOC, 0, 0, 0);
        send_command(CMD_READ, 2, 0, 0);
        send_command(CMD_FREE, 3, 2, 0);
        send_command(CMD_FREE, 0, 5, 0);
        send_command(CMD_FREE, 2, 9, 0);
        send_command(CMD_WRITE, 3, 0, 28'd3);
        send_command(CMD_ALLOC, 3, 0, 0);
        send_command(CMD_WRITE, 2, 0, 28'd100);
        send_command(CMD_FREE, 2, 0, 0);
        send_command(CMD_READ, 5, 0, 0);
        send_command(CMD_READ, 6, 0, 0);
        set_length(8191);
        send_command(CMD_WRITE, 4095, 0, 28'hFFFFFFF);
        send_command(CMD_READ, 4095, 4095, 0);
        send_command(CMD_WRITE, 4095, 0, 28'h5555555);
        send_command(CMD_READ, 4095, 0, 0);

        // Random phases with four length settings, small ones most of the time.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_length($urandom_range(3, 40));
                1: set_length($urandom_range(3, 12));
                2: set_length(4096);
                default: set_length($urandom_range(20, 200));
            endcase
            if (phase == 3) idle_enabled = 1'b0;
            for (int n = 0; n < 30; n++) random_command();
        end

        drain_results();
        if (fail_count == 0)
            $display("fat_cluster_chain_engine_top regression: pass");
        else
            $display("fat_cluster_chain_engine_top regression: fail");
        $finish;
    end

    initial begin
        #100_000_000;
        $display("fat_cluster_chain_engine_top regression: fail");
        $finish;
    end

endmodule

[filelist.f]
rtl/fcce_pkg.sv
rtl/fcce_ram.sv
rtl/fcce_ctrl.sv
rtl/fat_cluster_chain_engine_top.sv
test/tb_fat_cluster_chain_engine_checker.sv
test/tb_fat_cluster_chain_engine_top.sv
